// ----- hw/rtl/frame_header_trailer_wrapper_macros.svh -----
// Assertion macros shared by the frame wrapper modules
`ifndef FRAME_HEADER_TRAILER_WRAPPER_MACROS_SVH
`define FRAME_HEADER_TRAILER_WRAPPER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FHTW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FHTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fhtw_pkg.sv -----
// Package: widths, framing constants and the job type of the frame wrapper
package fhtw_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int LEN_W       = 24;

    // Valid length bits of the payload_length field
    localparam logic [LEN_W-1:0] LEN_MASK =
        LEN_W'((25'd1 << LENGTH_BITS) - 25'd1);

    // floor(x / 6) = (x * DIV6_MUL) >> DIV6_SHIFT, exact for x below 2^25
    localparam logic [LEN_W-1:0] DIV6_MUL   = 24'hAAAAAB;
    localparam int               DIV6_SHIFT = 26;

    localparam logic [7:0] START_MARKER [6] = '{8'hEA, 8'hFF, 8'h99, 8'hDE, 8'hAD, 8'hFF};
    localparam logic [7:0] END_MARKER   [6] = '{8'hEA, 8'hFF, 8'h99, 8'hDE, 8'hAD, 8'hAA};
    localparam logic [7:0] LAST_MASK    [6] = '{8'h01, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F};

    // Byte positions inside the header
    localparam logic [3:0] HDR_APP_ID   = 4'd6;
    localparam logic [3:0] HDR_CNT_HI   = 4'd7;
    localparam logic [3:0] HDR_CNT_MID  = 4'd8;
    localparam logic [3:0] HDR_CNT_LO   = 4'd9;
    localparam logic [3:0] HDR_MASK     = 4'd10;

    // Last byte index of each kind of job
    localparam logic [3:0] LAST_HEADER  = 4'd11;
    localparam logic [3:0] LAST_BYTE    = 4'd0;
    localparam logic [3:0] LAST_TRAILER = 4'd6;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_BYTE,
        JOB_BYTE_END
    } job_kind_t;

    // One unit of output work handed from the frame control to the emitter
    typedef struct packed {
        logic              valid;
        job_kind_t         kind;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  quot;
    } job_t;

endpackage

// ----- hw/rtl/fhtw_ifs.sv -----
// Stream interfaces: input byte requests and framed output bytes

interface fhtw_in_if;
    logic                     valid;
    logic                     ready;
    logic [7:0]               byte_value;
    logic                     starts_frame;
    logic [fhtw_pkg::LEN_W-1:0] payload_length;

    modport source (output valid, byte_value, starts_frame, payload_length, input ready);
    modport sink   (input valid, byte_value, starts_frame, payload_length, output ready);
endinterface

interface fhtw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, out_byte, run_last, frame_end, input ready);
    modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

// ----- hw/rtl/fhtw_frame_ctl.sv -----
// Frame control: tracks frame state, classifies requests and holds the next job
`include "frame_header_trailer_wrapper_macros.svh"

module fhtw_frame_ctl (
    input  logic                clk,
    input  logic                rst_n,
    fhtw_in_if.sink             byte_stream,
    input  logic                job_take,
    output fhtw_pkg::job_t      job
);

    fhtw_pkg::job_t                    job_reg,       job_next;
    logic [fhtw_pkg::LEN_W-1:0]        remaining_reg, remaining_next;
    logic                              in_frame_reg,  in_frame_next;

    logic                              accept;
    logic [fhtw_pkg::LEN_W-1:0]        len;
    logic [2*fhtw_pkg::LEN_W-1:0]      prod;
    logic [fhtw_pkg::LEN_W-1:0]        remaining_dec;

    // Job slot frees when the emitter finishes the job it holds
    assign byte_stream.ready = !job_reg.valid || job_take;
    assign accept = byte_stream.valid && byte_stream.ready;
    assign job    = job_reg;

    // Packet count divide by six as a reciprocal multiply
    assign len  = byte_stream.payload_length & fhtw_pkg::LEN_MASK;
    assign prod = (2*fhtw_pkg::LEN_W)'(len) * (2*fhtw_pkg::LEN_W)'(fhtw_pkg::DIV6_MUL);
    assign remaining_dec = remaining_reg - 1'b1;

    // Request classification and frame state update
    always_comb
    begin
        job_next       = job_reg;
        remaining_next = remaining_reg;
        in_frame_next  = in_frame_reg;
        if (job_take)
        begin
            job_next.valid = 1'b0;
        end
        if (accept)
        begin
            job_next.data = byte_stream.byte_value;
            job_next.len  = len;
            job_next.quot = fhtw_pkg::LEN_W'(prod >> fhtw_pkg::DIV6_SHIFT);
            if (byte_stream.starts_frame)
            begin
                // zero length start is dropped and leaves the frame alone
                if (len != '0)
                begin
                    job_next.valid = 1'b1;
                    job_next.kind  = fhtw_pkg::JOB_HEADER;
                    remaining_next = len;
                    in_frame_next  = 1'b1;
                end
            end
            else if (!in_frame_reg || remaining_reg == '0)
            begin
                // stray payload byte outside a frame
                in_frame_next = 1'b0;
            end
            else
            begin
                job_next.valid = 1'b1;
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    job_next.kind = fhtw_pkg::JOB_BYTE_END;
                    in_frame_next = 1'b0;
                end
                else
                begin
                    job_next.kind = fhtw_pkg::JOB_BYTE;
                end
            end
        end
    end

    // Job slot and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg       <= '0;
            remaining_reg <= '0;
            in_frame_reg  <= 1'b0;
        end
        else
        begin
            job_reg       <= job_next;
            remaining_reg <= remaining_next;
            in_frame_reg  <= in_frame_next;
        end
    end

    `FHTW_ASSERT_IMPL(a_frame_count, 1'b1, in_frame_reg == (remaining_reg != '0), "frame flag and byte count disagree")
    `FHTW_ASSERT_IMPL(a_end_closes, job_reg.valid && job_reg.kind == fhtw_pkg::JOB_BYTE_END, !in_frame_reg, "trailer job while frame still open")
    `FHTW_ASSERT_NEXT(a_header_opens, accept && byte_stream.starts_frame && len != '0, in_frame_reg && job_reg.valid, "accepted start did not open a frame")

endmodule

// ----- hw/rtl/fhtw_emitter.sv -----
// Emitter: walks the bytes of one job into the output register, one per cycle while frame_stream is not stalled
`include "frame_header_trailer_wrapper_macros.svh"

module fhtw_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  fhtw_pkg::job_t      job,
    output logic                job_take,
    fhtw_out_if.source          frame_stream
);

    logic [3:0]  idx_reg,       idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        run_last_reg,  run_last_next;
    logic        frame_end_reg, frame_end_next;

    logic                          advance;
    logic                          at_last;
    logic [3:0]                    last_idx;
    logic [fhtw_pkg::LEN_W-1:0]    quot6;
    logic [2:0]                    rem;
    logic [fhtw_pkg::LEN_W-1:0]    pkts;
    logic [2:0]                    trl_idx;

    // Remainder of len / 6 fits in three bits, so only the low bits subtract
    assign quot6 = (job.quot << 2) + (job.quot << 1);
    assign rem   = job.len[2:0] - quot6[2:0];
    assign pkts  = job.quot + fhtw_pkg::LEN_W'(rem != 3'd0);
    assign trl_idx = 3'(idx_reg - 4'd1);

    always_comb
    begin
        case (job.kind)
            fhtw_pkg::JOB_HEADER:   last_idx = fhtw_pkg::LAST_HEADER;
            fhtw_pkg::JOB_BYTE_END: last_idx = fhtw_pkg::LAST_TRAILER;
            default:                last_idx = fhtw_pkg::LAST_BYTE;
        endcase
    end

    assign advance  = job.valid && (!out_valid_reg || frame_stream.ready);
    assign at_last  = idx_reg == last_idx;
    assign job_take = advance && at_last;

    // Byte selection for the current position
    always_comb
    begin
        out_byte_next = job.data;
        case (job.kind)
            fhtw_pkg::JOB_HEADER:
            begin
                case (idx_reg) inside
                    [4'd0:4'd5]:           out_byte_next = fhtw_pkg::START_MARKER[idx_reg[2:0]];
                    fhtw_pkg::HDR_APP_ID:  out_byte_next = job.data;
                    fhtw_pkg::HDR_CNT_HI:  out_byte_next = pkts[23:16];
                    fhtw_pkg::HDR_CNT_MID: out_byte_next = pkts[15:8];
                    fhtw_pkg::HDR_CNT_LO:  out_byte_next = pkts[7:0];
                    fhtw_pkg::HDR_MASK:    out_byte_next = fhtw_pkg::LAST_MASK[rem];
                    default:               out_byte_next = 8'h00;
                endcase
            end
            fhtw_pkg::JOB_BYTE_END:
            begin
                if (idx_reg != 4'd0)
                begin
                    out_byte_next = fhtw_pkg::END_MARKER[trl_idx];
                end
            end
            default:
            begin
                out_byte_next = job.data;
            end
        endcase
        run_last_next  = at_last;
        frame_end_next = at_last && job.kind == fhtw_pkg::JOB_BYTE_END;
    end

    // Position counter and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !frame_stream.ready;
        if (advance)
        begin
            idx_next       = at_last ? 4'd0 : idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= out_byte_next;
            run_last_reg  <= run_last_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign frame_stream.valid     = out_valid_reg;
    assign frame_stream.out_byte  = out_byte_reg;
    assign frame_stream.run_last  = run_last_reg;
    assign frame_stream.frame_end = frame_end_reg;

    `FHTW_ASSERT_IMPL(a_idx_in_job, idx_reg != 4'd0, job.valid && idx_reg <= last_idx, "byte position outside current job")
    `FHTW_ASSERT_IMPL(a_end_is_last, out_valid_reg && frame_end_reg, run_last_reg, "frame end not on last byte of request")

endmodule

// ----- hw/rtl/frame_header_trailer_wrapper.sv -----
// Top level of the frame header/trailer wrapper
//
//  channel       dir  handshake     payload
//  byte_stream   in   valid/ready   byte_value[7:0], starts_frame, payload_length[23:0]
//  frame_stream  out  valid/ready   out_byte[7:0], run_last, frame_end
//
// While frame_stream accepts, one output byte per cycle leaves through a single output register, which sets the pace:
// a payload byte yields 1 output byte, a start request 12 bytes, the last payload byte 7 bytes.
// Dropped requests (zero length start, byte outside a frame) are accepted and emit nothing.
// A one-entry job slot in front of the emitter lets the next request be accepted while
// the last byte of the previous one waits; stalls on frame_stream back up into byte_stream.
// rst_n clears the frame state, the job slot and the output valid asynchronously.

module frame_header_trailer_wrapper (
    input  logic        clk,
    input  logic        rst_n,
    fhtw_in_if.sink     byte_stream,
    fhtw_out_if.source  frame_stream
);

    fhtw_pkg::job_t  job;
    logic            job_take;

    fhtw_frame_ctl u_frame_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .job_take    (job_take),
        .job         (job)
    );

    fhtw_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_take     (job_take),
        .frame_stream (frame_stream)
    );

endmodule

// ----- sim/tb_frame_header_trailer_wrapper.sv -----
// Testbench for the frame header/trailer wrapper: random byte requests, predicted framed bytes
module tb_frame_header_trailer_wrapper;
    timeunit 1ns;
    timeprecision 1ps;

    // One input request plus the idle cycles the driver waits before offering it
    typedef struct packed {
        logic [7:0]                 byte_value;
        logic                       starts_frame;
        logic [fhtw_pkg::LEN_W-1:0] payload_length;
        logic [3:0]                 gap;
    } byte_req_t;

    // One byte of the framed output stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } frame_byte_t;

    localparam logic [7:0] SOF_BYTES [6] = '{8'hEA, 8'hFF, 8'h99, 8'hDE, 8'hAD, 8'hFF};
    localparam logic [7:0] EOF_BYTES [6] = '{8'hEA, 8'hFF, 8'h99, 8'hDE, 8'hAD, 8'hAA};
    localparam int         HOLD_CYCLES   = 120;
    localparam int         HOLD_AT_REQ   = 45;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the block inputs, known from time zero
    logic                       src_valid  = 1'b0;
    logic [7:0]                 src_byte   = 8'h00;
    logic                       src_start  = 1'b0;
    logic [fhtw_pkg::LEN_W-1:0] src_len    = '0;
    logic                       snk_ready  = 1'b0;

    fhtw_in_if  byte_if ();
    fhtw_out_if frame_if ();

    assign byte_if.valid          = src_valid;
    assign byte_if.byte_value     = src_byte;
    assign byte_if.starts_frame   = src_start;
    assign byte_if.payload_length = src_len;
    assign frame_if.ready         = snk_ready;

    frame_header_trailer_wrapper u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .frame_stream (frame_if)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_req_t   pending_reqs [$];
    frame_byte_t bytes_due [$];
    byte_req_t   cur_req;
    int          reqs_accepted = 0;
    int          bytes_seen    = 0;
    int          error_count   = 0;
    int          wait_cnt      = 0;
    int          stall_left    = 0;
    logic        hold_off      = 1'b0;
    bit          no_gaps       = 1'b0;

    // Framer state of the predictor
    logic [fhtw_pkg::LEN_W-1:0] frm_left = '0;
    logic                       frm_open = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic frame_byte_t fb(input logic [7:0] b, input logic fe);
        frame_byte_t r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.frame_end = fe;
        return r;
    endfunction

    // Work out the framed bytes one accepted request causes
    task automatic predict_framing(input byte_req_t r);
        logic [fhtw_pkg::LEN_W-1:0] len;
        int unsigned                rem;
        int unsigned                pkts;
        frame_byte_t                outb [$];
        len = r.payload_length & fhtw_pkg::LEN_MASK;
        if (r.starts_frame)
        begin
            // zero length start is rejected, frame state untouched
            if (len != 0)
            begin
                rem  = len % 6;
                pkts = len / 6 + ((rem != 0) ? 1 : 0);
                for (int i = 0; i < 6; i++)
                    outb.push_back(fb(SOF_BYTES[i], 1'b0));
                outb.push_back(fb(r.byte_value, 1'b0));
                outb.push_back(fb(pkts[23:16], 1'b0));
                outb.push_back(fb(pkts[15:8], 1'b0));
                outb.push_back(fb(pkts[7:0], 1'b0));
                outb.push_back(fb((rem == 0) ? 8'h01 : 8'((1 << rem) - 1), 1'b0));
                outb.push_back(fb(8'h00, 1'b0));
                frm_left = len;
                frm_open = 1'b1;
            end
        end
        else if (!frm_open || frm_left == 0)
        begin
            // stray byte outside a frame is dropped
            frm_open = 1'b0;
        end
        else
        begin
            outb.push_back(fb(r.byte_value, 1'b0));
            frm_left = frm_left - 1'b1;
            if (frm_left == 0)
            begin
                for (int i = 0; i < 6; i++)
                    outb.push_back(fb(EOF_BYTES[i], i == 5));
                frm_open = 1'b0;
            end
        end
        if (outb.size() > 0)
        begin
            outb[outb.size()-1].run_last = 1'b1;
            foreach (outb[i])
                bytes_due.push_back(outb[i]);
        end
    endtask

    // Compare one accepted output byte against the oldest expectation
    task automatic check_frame_byte(input logic [7:0] b, input logic rl, input logic fe);
        frame_byte_t e;
        if (bytes_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %02h", b));
        end
        else
        begin
            e = bytes_due.pop_front();
            if (b !== e.out_byte)
                report_mismatch($sformatf("byte %0d out_byte %02h, want %02h",
                                          bytes_seen, b, e.out_byte));
            if (rl !== e.run_last)
                report_mismatch($sformatf("byte %0d run_last %b, want %b",
                                          bytes_seen, rl, e.run_last));
            if (fe !== e.frame_end)
                report_mismatch($sformatf("byte %0d frame_end %b, want %b",
                                          bytes_seen, fe, e.frame_end));
        end
    endtask

    task automatic add_req(input logic [7:0] b, input logic s,
                           input logic [fhtw_pkg::LEN_W-1:0] len);
        byte_req_t r;
        r.byte_value     = b;
        r.starts_frame   = s;
        r.payload_length = len;
        // a window with no gaps lets the sender push while the receiver holds off
        if (no_gaps || (pending_reqs.size() >= 40 && pending_reqs.size() < 95))
            r.gap = 4'd0;
        else
            r.gap = 4'($urandom_range(0, 10));
        pending_reqs.push_back(r);
    endtask

    function automatic logic [fhtw_pkg::LEN_W-1:0] rand_len24();
        return fhtw_pkg::LEN_W'($urandom);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            wait_cnt  <= 0;
        end
        else
        begin
            if (src_valid && byte_if.ready)
            begin
                predict_framing(cur_req);
                reqs_accepted++;
            end
            if (!src_valid || byte_if.ready)
            begin
                if (pending_reqs.size() == 0)
                begin
                    src_valid <= 1'b0;
                end
                else if (wait_cnt < int'(pending_reqs[0].gap))
                begin
                    src_valid <= 1'b0;
                    wait_cnt  <= wait_cnt + 1;
                end
                else
                begin
                    cur_req = pending_reqs.pop_front();
                    src_valid <= 1'b1;
                    src_byte  <= cur_req.byte_value;
                    src_start <= cur_req.starts_frame;
                    src_len   <= cur_req.payload_length;
                    wait_cnt  <= 0;
                end
            end
        end
    end

    // Output monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin : frame_mon
        logic nxt_ready;
        int   d;
        if (!rst_n)
        begin
            snk_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            nxt_ready = 1'b1;
            if (frame_if.valid && snk_ready)
            begin
                check_frame_byte(frame_if.out_byte, frame_if.run_last, frame_if.frame_end);
                bytes_seen++;
                // every third stretch of bytes runs without stalls
                d = (((bytes_seen / 100) % 3) == 2) ? 0 : $urandom_range(0, 10);
                if (d > 0)
                begin
                    stall_left <= d - 1;
                    nxt_ready = 1'b0;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                nxt_ready = 1'b0;
            end
            if (hold_off)
                nxt_ready = 1'b0;
            snk_ready <= nxt_ready;
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (reqs_accepted >= HOLD_AT_REQ);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stimulus and end of run
    initial
    begin
        int          kind;
        int unsigned flen;
        int unsigned part;
        int          total;

        // directed: stray byte and zero length start while idle
        add_req(8'h00, 1'b0, 24'h000000);
        add_req(8'hFF, 1'b1, 24'h000000);
        // shortest frame
        add_req(8'h00, 1'b1, 24'd1);
        add_req(8'hFF, 1'b0, 24'hFFFFFF);
        // whole packet, remainder zero
        add_req(8'hA5, 1'b1, 24'd6);
        for (int i = 0; i < 6; i++)
            add_req(8'(i * 51), 1'b0, 24'h000000);
        // zero length start mid-frame keeps the frame, then a start abandons it
        add_req(8'h3C, 1'b1, 24'd5);
        add_req(8'h11, 1'b0, 24'h000000);
        add_req(8'h22, 1'b0, 24'hFFFFFF);
        add_req(8'h77, 1'b1, 24'd0);
        add_req(8'h33, 1'b0, 24'h000000);
        add_req(8'hC3, 1'b1, 24'd2);
        add_req(8'h44, 1'b0, 24'h000000);
        add_req(8'h55, 1'b0, 24'h000000);
        // largest length, abandoned by a shorter frame
        add_req(8'h5A, 1'b1, 24'hFFFFFF);
        add_req(8'h66, 1'b0, 24'h000000);
        add_req(8'h96, 1'b1, 24'd3);
        add_req(8'h80, 1'b0, 24'h000000);
        add_req(8'h01, 1'b0, 24'h000000);
        add_req(8'h7F, 1'b0, 24'h000000);
        // stray byte after the frame closed
        add_req(8'hEE, 1'b0, 24'h000000);

        // random: mostly well-formed frames, some broken ones and noise
        total = pending_reqs.size() + 118;
        while (pending_reqs.size() < total)
        begin
            kind    = $urandom_range(0, 9);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (kind < 7)
            begin
                flen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                add_req(8'($urandom), 1'b1, fhtw_pkg::LEN_W'(flen));
                for (int unsigned k = 0; k < flen; k++)
                    add_req(8'($urandom), 1'b0, rand_len24());
            end
            else if (kind == 7)
            begin
                // huge length, left open for the next start to abandon
                add_req(8'($urandom), 1'b1, rand_len24() | 24'h1);
                part = $urandom_range(0, 3);
                for (int unsigned k = 0; k < part; k++)
                    add_req(8'($urandom), 1'b0, rand_len24());
            end
            else if (kind == 8)
            begin
                // short frame cut off, with a zero length start inside
                flen = $urandom_range(2, 12);
                add_req(8'($urandom), 1'b1, fhtw_pkg::LEN_W'(flen));
                part = $urandom_range(0, flen - 1);
                for (int unsigned k = 0; k < part; k++)
                    add_req(8'($urandom), 1'b0, rand_len24());
                add_req(8'($urandom), 1'b1, 24'd0);
            end
            else
            begin
                part = $urandom_range(1, 3);
                for (int unsigned k = 0; k < part; k++)
                    add_req(8'($urandom), 1'b0, rand_len24());
            end
        end
        no_gaps = 1'b0;
        total = pending_reqs.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (reqs_accepted == total);
        wait (bytes_due.size() == 0);
        repeat (30) @(posedge clk);
        if (error_count == 0 && bytes_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
